// File: rtl/ralloc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the region list allocator.
package ralloc_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_REGIONS = 16;

    localparam int ADDR_W     = 32;
    localparam int PAGES_W    = 21;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int COUNT_W    = $clog2(MAX_REGIONS + 1);

    localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

    // Stream payload widths
    localparam int S_TDATA_W   = 2 * ADDR_W;
    localparam int M_FIELDS_W  = ADDR_W + PAGES_W + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = ADDR_W;

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [M_TUSER_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POOL_BASE = 1'b0,
        REG_POOL_SIZE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic occupied;   // cell index below the region count
        logic load_new;   // take the freshly allocated region
        logic shift;      // release commits: cells at or past the hit pull from above
    } cell_ctl_t;

endpackage

// File: rtl/region_list_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the region list allocator: sequencer, cell chain and output register.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser carries the
//   command (0 allocate, 1 release); s_tdata carries size_bytes and address.
//   Each word yields exactly one result word on m_tvalid/m_tready/m_tdata/m_tuser:
//   status in m_tuser, region base, page count and the in-pool flag in m_tdata.
//   pool_base and pool_size are written through cfg_we/cfg_addr/cfg_wdata while
//   the block is idle; a write takes effect at the next clock edge.
// Timing:
//   An accepted word is latched, then executed once the output register is free;
//   its result word is registered there and leaves on the m_tvalid/m_tready handshake.
//   One word is in flight at a time:
//   no new word is taken until the latched word has gone through the
//   compare-and-shift of the cell chain.
// Reset (aresetn low, synchronous): the region list empties, the pool registers
//   clear, the output word is dropped and the sequencer returns to idle.
// Stall: while m_tready is low the finished word holds in the output register;
//   the next input word is still accepted and latched, and its execution waits
//   until the output register frees up.
module region_list_allocator_top
    import ralloc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] size_bytes, [63:32] address
    input  logic                  s_tuser,   // [0] cmd
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] region_base, [52:32] page_count,
                                             // [53] in_pool, rest zero
    output logic [M_TUSER_W-1:0]  m_tuser    // [1:0] status
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] pool_base_reg;
    logic [ADDR_W-1:0] pool_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
            pool_size_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_POOL_BASE: pool_base_reg <= cfg_wdata[ADDR_W-1:0];
                REG_POOL_SIZE: pool_size_reg <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   accept;
    logic   exec_fire;
    logic   m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)    state_next = ST_EXEC;
            ST_EXEC: if (exec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = aresetn;
            ST_EXEC: exec_fire = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // latch the accepted word
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_tuser);
            size_reg <= s_tdata[ADDR_W-1:0];
            addr_reg <= s_tdata[2*ADDR_W-1:ADDR_W];
        end
    end

    // ------------------------------------------------------------------
    // Region count
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               full;
    logic               alloc_commit;
    logic               release_commit;
    logic               found_any;

    assign full           = (count_reg == COUNT_W'(MAX_REGIONS));
    assign alloc_commit   = exec_fire && (cmd_reg == CMD_ALLOC) && !full;
    assign release_commit = exec_fire && (cmd_reg == CMD_RELEASE) && found_any;

    always_comb begin
        count_next = count_reg;
        if (alloc_commit) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (release_commit) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  cell_base  [MAX_REGIONS];
    logic [PAGES_W-1:0] cell_pages [MAX_REGIONS];
    logic               cell_match [MAX_REGIONS];
    logic [MAX_REGIONS:0] found;
    logic [ADDR_W-1:0]  new_base;
    logic [PAGES_W-1:0] new_pages;

    assign found[0]  = 1'b0;
    assign found_any = found[MAX_REGIONS];

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        cell_ctl_t          ctl;
        logic [ADDR_W-1:0]  nbr_base;
        logic [PAGES_W-1:0] nbr_pages;

        assign ctl.occupied = (COUNT_W'(i) < count_reg);
        assign ctl.load_new = alloc_commit && (COUNT_W'(i) == count_reg);
        assign ctl.shift    = release_commit;

        if (i == MAX_REGIONS - 1) begin : g_top_end
            // nothing above the last cell; its entry falls out of the count
            assign nbr_base  = cell_base[i];
            assign nbr_pages = cell_pages[i];
        end else begin : g_inner
            assign nbr_base  = cell_base[i+1];
            assign nbr_pages = cell_pages[i+1];
        end

        ralloc_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_base  (new_base),
            .new_pages (new_pages),
            .nbr_base  (nbr_base),
            .nbr_pages (nbr_pages),
            .addr      (addr_reg),
            .found_in  (found[i]),
            .base      (cell_base[i]),
            .pages     (cell_pages[i]),
            .match     (cell_match[i]),
            .found_out (found[i+1])
        );
    end

    // first hit and last listed entry, gathered from the cells
    logic [ADDR_W-1:0]  hit_base;
    logic [PAGES_W-1:0] hit_pages;
    logic [ADDR_W-1:0]  last_base;
    logic [PAGES_W-1:0] last_pages;

    always_comb begin
        hit_base   = '0;
        hit_pages  = '0;
        last_base  = '0;
        last_pages = '0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            if (cell_match[i] && !found[i]) begin
                hit_base  = hit_base  | cell_base[i];
                hit_pages = hit_pages | cell_pages[i];
            end
            if (COUNT_W'(i + 1) == count_reg) begin
                last_base  = last_base  | cell_base[i];
                last_pages = last_pages | cell_pages[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Allocation arithmetic
    // ------------------------------------------------------------------
    logic [ADDR_W:0]              size_round;
    logic [ADDR_W:0]              pages_raw;
    logic [PAGES_W+PAGE_SHIFT-1:0] last_span;

    assign size_round = {1'b0, size_reg} + (ADDR_W+1)'(PAGE_BYTES - 1);
    assign pages_raw  = size_round >> PAGE_SHIFT;
    // saturate the page count to the field width
    assign new_pages  = (pages_raw > (ADDR_W+1)'(PAGES_MAX)) ? PAGES_MAX
                                                              : pages_raw[PAGES_W-1:0];
    assign last_span  = {last_pages, {PAGE_SHIFT{1'b0}}};
    assign new_base   = (count_reg == '0) ? pool_base_reg + ADDR_W'(PAGE_BYTES)
                                          : last_base + ADDR_W'(last_span);

    // pool check: top computed one bit wider, top itself inside
    logic [ADDR_W:0] pool_top;
    logic            in_pool;

    assign pool_top = {1'b0, pool_base_reg} + {1'b0, pool_size_reg};
    assign in_pool  = (addr_reg >= pool_base_reg) && ({1'b0, addr_reg} <= pool_top);

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    status_t            status_next;
    logic [ADDR_W-1:0]  res_base_next;
    logic [PAGES_W-1:0] res_pages_next;

    always_comb begin
        status_next    = STAT_OK;
        res_base_next  = '0;
        res_pages_next = '0;
        case (cmd_reg)
            CMD_ALLOC: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    res_base_next  = new_base;
                    res_pages_next = new_pages;
                end
            end
            CMD_RELEASE: begin
                if (found_any) begin
                    res_base_next  = hit_base;
                    res_pages_next = hit_pages;
                end else begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    status_t            status_reg;
    logic [ADDR_W-1:0]  res_base_reg;
    logic [PAGES_W-1:0] res_pages_reg;
    logic               in_pool_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            status_reg    <= status_next;
            res_base_reg  <= res_base_next;
            res_pages_reg <= res_pages_next;
            in_pool_reg   <= in_pool;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_TDATA_W'({in_pool_reg, res_pages_reg, res_base_reg});

endmodule

// File: rtl/ralloc_cell.sv
`timescale 1ns / 1ps
// One list cell: holds a region entry, compares it and shifts down on release.
module ralloc_cell
    import ralloc_pkg::*;
(
    input  logic               aclk,
    input  cell_ctl_t          ctl,
    input  logic [ADDR_W-1:0]  new_base,
    input  logic [PAGES_W-1:0] new_pages,
    input  logic [ADDR_W-1:0]  nbr_base,
    input  logic [PAGES_W-1:0] nbr_pages,
    input  logic [ADDR_W-1:0]  addr,
    input  logic               found_in,
    output logic [ADDR_W-1:0]  base,
    output logic [PAGES_W-1:0] pages,
    output logic               match,
    output logic               found_out
);

    logic [ADDR_W-1:0]  base_reg;
    logic [PAGES_W-1:0] pages_reg;

    assign match     = ctl.occupied && (base_reg == addr);
    assign found_out = found_in || match;
    assign base      = base_reg;
    assign pages     = pages_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load_new) begin
            base_reg  <= new_base;
            pages_reg <= new_pages;
        end else if (ctl.shift && found_out) begin
            // pull the upper neighbor down over the removed entry
            base_reg  <= nbr_base;
            pages_reg <= nbr_pages;
        end
    end

endmodule

// File: rtl/ralloc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the region list allocator, bound to the top level.
module ralloc_checker
    import ralloc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // one word in flight: no second word right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in flight");

    // status is always one of the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_FULL ||
                      m_tuser == STAT_NOT_FOUND))
        else $error("undefined status code");

    // a failed word reports zero base and zero pages
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[ADDR_W+PAGES_W-1:0] == '0))
        else $error("failed word carries a region");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind region_list_allocator_top ralloc_checker u_ralloc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/region_list_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for the region list allocator: tracks the region list and scores every result word.
module region_list_allocator_checker
    import ralloc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] size_bytes, [63:32] address
    input  logic                  s_tuser,   // [0] cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] region_base, [52:32] page_count,
                                             // [53] in_pool
    input  logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] status
    input  logic                  end_of_test,
    output int                    fail_count
);

    typedef struct {
        status_t             status;
        logic [ADDR_W-1:0]   base;
        logic [PAGES_W-1:0]  pages;
        logic                in_pool;
    } region_reply_t;

    logic [ADDR_W-1:0]  list_base  [MAX_REGIONS];
    logic [PAGES_W-1:0] list_pages [MAX_REGIONS];
    int                 list_len;
    logic [ADDR_W-1:0]  pool_base_q;
    logic [ADDR_W-1:0]  pool_size_q;
    region_reply_t      pending_replies[$];
    bit                 leftovers_checked;

    initial begin
        fail_count        = 0;
        list_len          = 0;
        leftovers_checked = 0;
    end

    task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    // Advance the region list by one word and return the reply it should produce.
    function automatic region_reply_t apply_region_op(cmd_t op, logic [ADDR_W-1:0] nbytes,
                                                      logic [ADDR_W-1:0] addr);
        region_reply_t r;
        logic [63:0]   npages;
        logic [63:0]   next_end;
        logic [ADDR_W:0] pool_top;
        int            hit;
        r.status = STAT_OK;
        r.base   = '0;
        r.pages  = '0;
        if (op == CMD_ALLOC) begin
            if (list_len >= MAX_REGIONS) begin
                r.status = STAT_FULL;
            end else begin
                npages = (64'(nbytes) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
                if (npages > 64'(PAGES_MAX))
                    npages = 64'(PAGES_MAX);
                if (list_len == 0)
                    next_end = 64'(pool_base_q) + 64'(PAGE_BYTES);
                else
                    next_end = 64'(list_base[list_len-1]) +
                               64'(list_pages[list_len-1]) * 64'(PAGE_BYTES);
                list_base[list_len]  = next_end[ADDR_W-1:0];
                list_pages[list_len] = npages[PAGES_W-1:0];
                list_len++;
                r.base  = next_end[ADDR_W-1:0];
                r.pages = npages[PAGES_W-1:0];
            end
        end else begin
            hit = -1;
            for (int i = 0; i < list_len; i++)
                if (hit < 0 && list_base[i] == addr)
                    hit = i;
            if (hit < 0) begin
                r.status = STAT_NOT_FOUND;
            end else begin
                r.base  = list_base[hit];
                r.pages = list_pages[hit];
                for (int i = hit; i + 1 < list_len; i++) begin
                    list_base[i]  = list_base[i+1];
                    list_pages[i] = list_pages[i+1];
                end
                list_len--;
            end
        end
        // the pool top is inclusive and never wraps
        pool_top  = {1'b0, pool_base_q} + {1'b0, pool_size_q};
        r.in_pool = (addr >= pool_base_q) && ({1'b0, addr} <= pool_top);
        return r;
    endfunction

    always @(posedge aclk) begin
        region_reply_t want;
        region_reply_t got;
        if (!aresetn) begin
            list_len    = 0;
            pool_base_q = '0;
            pool_size_q = '0;
            pending_replies.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_POOL_BASE: pool_base_q = cfg_wdata;
                    REG_POOL_SIZE: pool_size_q = cfg_wdata;
                    default: ;
                endcase
            end
            // score the outgoing word before queuing the incoming one
            if (m_tvalid && m_tready) begin
                got.status  = status_t'(m_tuser);
                got.base    = m_tdata[ADDR_W-1:0];
                got.pages   = m_tdata[ADDR_W +: PAGES_W];
                got.in_pool = m_tdata[ADDR_W+PAGES_W];
                if (pending_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with nothing outstanding", $realtime);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status)
                        flag_field("status", 64'(want.status), 64'(m_tuser));
                    if (got.base !== want.base)
                        flag_field("region_base", 64'(want.base), 64'(got.base));
                    if (got.pages !== want.pages)
                        flag_field("page_count", 64'(want.pages), 64'(got.pages));
                    if (got.in_pool !== want.in_pool)
                        flag_field("in_pool", 64'(want.in_pool), 64'(got.in_pool));
                end
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_region_op(cmd_t'(s_tuser),
                                                          s_tdata[ADDR_W-1:0],
                                                          s_tdata[ADDR_W +: ADDR_W]));
            if (end_of_test && !leftovers_checked) begin
                leftovers_checked = 1;
                if (pending_replies.size() != 0) begin
                    fail_count += pending_replies.size();
                    $display("%0t: %0d result words never arrived", $realtime,
                             pending_replies.size());
                end
            end
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the region list allocator: clock, reset, stimulus and verdict.
module testbench;
    import ralloc_pkg::*;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_POOL_BASE;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;   // [31:0] size_bytes, [63:32] address
    logic                  s_tuser     = 1'b0; // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // [31:0] region_base, [52:32] page_count,
                                               // [53] in_pool
    logic [M_TUSER_W-1:0]  m_tuser;            // [1:0] status
    logic                  end_of_test = 1'b0;
    int                    fail_count;

    // Bookkeeping used only to shape stimulus: words in flight and the bases that
    // the block has handed out and not yet taken back.
    int                    n_sent = 0;
    int                    n_recv = 0;
    cmd_t                  cmd_log[$];
    logic [ADDR_W-1:0]     live_bases[$];
    logic [ADDR_W-1:0]     pool_base_now = '0;
    logic [ADDR_W-1:0]     pool_size_now = '0;

    // Flow control knobs shared by the sender and the receiver.
    bit                    steady_flow   = 0;  // no idling on either side
    bit                    stall_request = 0;  // receiver starts a long hold-off
    int                    stall_left    = 0;
    int                    alloc_weight  = 50; // percent of random words that allocate

    region_list_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    region_list_allocator_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .end_of_test (end_of_test),
        .fail_count  (fail_count)
    );

    always #6 aclk = ~aclk;

    // Hard stop in case the handshakes lock up.
    initial begin
        #6_000_000;
        $display("region_list_allocator_top verification failed");
        $finish;
    end

    // Receiver: random back-pressure, a long hold-off on request, and none at all
    // while steady_flow is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_request && stall_left == 0) begin
                stall_left    = 90;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (steady_flow) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // Follow the result stream to learn which bases are live, so that most
    // releases name a region that exists.
    always @(posedge aclk) begin
        cmd_t              op;
        logic [ADDR_W-1:0] rbase;
        int                idx;
        if (aresetn && m_tvalid && m_tready) begin
            n_recv++;
            op = CMD_ALLOC;
            if (cmd_log.size() > 0)
                op = cmd_log.pop_front();
            rbase = m_tdata[ADDR_W-1:0];
            if (status_t'(m_tuser) == STAT_OK) begin
                if (op == CMD_ALLOC) begin
                    live_bases.push_back(rbase);
                end else begin
                    idx = -1;
                    foreach (live_bases[i])
                        if (idx < 0 && live_bases[i] == rbase)
                            idx = i;
                    if (idx >= 0)
                        live_bases.delete(idx);
                end
            end
        end
    end

    // Offer one word, after a random gap unless steady_flow is set, and hold it
    // until the block takes it. Call at a rising edge.
    task automatic send_word(cmd_t op, logic [ADDR_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(0, 99) < 22)
                gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {addr, nbytes};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        cmd_log.push_back(op);
    endtask

    // Drop valid and hold until every word sent has come back, then let the
    // latch/execute pipe settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (n_sent != n_recv)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both pool registers; the block must be idle.
    task automatic write_pool(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_POOL_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_addr  <= REG_POOL_SIZE;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        pool_base_now = base;
        pool_size_now = size;
    endtask

    // Release every live region one at a time so the next allocate starts
    // again one page above the pool base.
    task automatic clear_regions();
        while (live_bases.size() > 0) begin
            send_word(CMD_RELEASE, $urandom, live_bases[0]);
            drain_results();
        end
    endtask

    // One random word: mostly allocates and releases of live bases, with sizes
    // and addresses biased toward page edges and the pool bounds.
    task automatic random_word();
        logic [ADDR_W-1:0] nbytes;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   pool_top;
        pool_top = {1'b0, pool_base_now} + {1'b0, pool_size_now};
        case ($urandom_range(0, 9))
            0:       nbytes = '0;
            1, 2:    nbytes = $urandom_range(1, 3 * PAGE_BYTES);
            3:       nbytes = PAGE_BYTES * $urandom_range(1, 64);
            4:       nbytes = PAGE_BYTES * $urandom_range(1, 64) + 1;
            5:       nbytes = PAGE_BYTES * $urandom_range(1, 64) - 1;
            6:       nbytes = $urandom;
            7:       nbytes = 32'hFFFF_FFFF - $urandom_range(0, PAGE_BYTES);
            default: nbytes = $urandom_range(1, 20 * PAGE_BYTES);
        endcase
        case ($urandom_range(0, 7))
            0:       addr = pool_base_now;
            1:       addr = pool_base_now - 1;
            2:       addr = pool_top[ADDR_W-1:0];
            3:       addr = pool_top[ADDR_W-1:0] + 1;
            4:       addr = pool_base_now + $urandom_range(0, 64 * PAGE_BYTES);
            default: addr = $urandom;
        endcase
        if ($urandom_range(0, 99) < alloc_weight) begin
            send_word(CMD_ALLOC, nbytes, addr);
        end else begin
            if (live_bases.size() > 0 && $urandom_range(0, 99) < 80)
                addr = live_bases[$urandom_range(0, live_bases.size() - 1)];
            send_word(CMD_RELEASE, nbytes, addr);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] phase_base [6];
        logic [ADDR_W-1:0] phase_size [6];
        int                phase_weight [6];

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: pool at 64 KiB, 128 KiB long.
        write_pool(32'h0001_0000, 32'h0002_0000);
        send_word(CMD_RELEASE, 32'hFFFF_FFFF, 32'h0001_0000); // empty list, pool bottom
        send_word(CMD_ALLOC, 32'h0, 32'h0);                    // zero pages, below pool
        send_word(CMD_ALLOC, 32'h1, 32'h0003_0000);            // same base again, pool top
        drain_results();
        send_word(CMD_RELEASE, 32'h0, live_bases[0]);          // duplicate: lowest entry goes
        send_word(CMD_ALLOC, PAGE_BYTES, 32'h0003_0001);       // exact page, just above top
        send_word(CMD_ALLOC, PAGE_BYTES + 1, 32'hFFFF_FFFF);   // one byte over a page
        send_word(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0000_FFFF);    // largest size; the next base wraps
        send_word(CMD_ALLOC, 32'hFFFF_F001, 32'h0001_8000);
        repeat (11)
            send_word(CMD_ALLOC, $urandom_range(1, 8 * PAGE_BYTES), $urandom);
        send_word(CMD_ALLOC, 32'h2000, 32'h0001_0000);         // table full
        drain_results();
        send_word(CMD_RELEASE, 32'h0, live_bases[live_bases.size() / 2]); // shift down
        send_word(CMD_RELEASE, 32'h0, 32'h0001_0000);          // base not in the list
        send_word(CMD_ALLOC, 32'h0, 32'h0002_0000);            // refill to the limit
        send_word(CMD_ALLOC, 32'h1000, 32'h0);                 // full again
        drain_results();
        send_word(CMD_RELEASE, 32'h0, live_bases[0]);
        drain_results();

        // Random part: each phase changes the pool and the allocate/release mix.
        phase_base   = '{32'h0,         32'hFFFF_FFFF, 32'hFFFF_F000,
                         32'h8000_0000, $urandom & 32'hFFFF_F000, $urandom};
        phase_size   = '{32'h0,         32'hFFFF_FFFF, 32'h0000_2000,
                         32'h7FFF_FFFF, $urandom,      $urandom};
        phase_weight = '{60, 55, 45, 70, 40, 50};
        for (int p = 0; p < 6; p++) begin
            write_pool(phase_base[p], phase_size[p]);
            alloc_weight = phase_weight[p];
            steady_flow  = (p == 3);
            // start phases 2 and 4 from an empty list; in phase 2 the first base wraps
            if (p == 2 || p == 4)
                clear_regions();
            for (int n = 0; n < 190; n++) begin
                // fill the block up behind a stalled receiver
                if ((p == 1 || p == 4) && n == 60)
                    stall_request = 1;
                // let the sender sit until the result stream is empty
                if (n == 120)
                    drain_results();
                random_word();
            end
            drain_results();
        end

        steady_flow = 0;
        drain_results();
        repeat (8) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("region_list_allocator_top verification clean");
        end else begin
            $display("region_list_allocator_top verification failed");
        end
        $finish;
    end

endmodule
